// ===== src/ljf_pkg.sv =====
// types, constants and helper functions shared by the pair force pipeline
`default_nettype none
package ljf_pkg;

  // coordinate and fixed point formats
  localparam int CW   = 32;           // coordinate and force width
  localparam int FB   = 16;           // fraction bits
  localparam int R0W  = 32;           // zero-point distance register width
  localparam int DW   = CW + 1;       // coordinate difference magnitude width
  localparam int SQW  = 2 * DW;       // sum of squares width
  localparam int NUMW = R0W + FB;     // ratio dividend width
  localparam int PW   = 2 * CW;       // power product width
  localparam int CPW  = DW + CW;      // component product width

  localparam logic [R0W-1:0] R0_RESET = R0W'(65536);
  localparam logic [CW-1:0]  MAX_POS  = {1'b0, {(CW-1){1'b1}}};
  localparam logic [CW-1:0]  MIN_MAG  = {1'b1, {(CW-1){1'b0}}};
  localparam logic [CW-1:0]  UMAX     = {CW{1'b1}};

  typedef struct packed {
    logic signed [CW-1:0] a_x;
    logic signed [CW-1:0] a_y;
    logic signed [CW-1:0] b_x;
    logic signed [CW-1:0] b_y;
  } in_t;

  typedef struct packed {
    logic signed [CW-1:0] force_x;
    logic signed [CW-1:0] force_y;
    logic                 coincident;
    logic                 clipped;
  } out_t;

  // difference magnitudes and signs
  typedef struct packed {
    logic [DW-1:0] mx;
    logic [DW-1:0] my;
    logic          nx;
    logic          ny;
    logic          coinc;
  } geom_t;

  // geometry plus distance
  typedef struct packed {
    geom_t         g;
    logic [DW-1:0] d;
  } dist_t;

  // state carried through the power chain
  typedef struct packed {
    dist_t         t;
    logic [CW-1:0] s;
    logic [CW-1:0] p;
    logic [CW-1:0] s6;
    logic [PW-1:0] prod;
    logic          clip;
    logic          psat;
  } pow_t;

  // flags carried through the component dividers
  typedef struct packed {
    logic neg;
    logic coinc;
    logic clip;
  } comp_side_t;

  // truncate a Q product back to the power format, flag overflow
  function automatic logic [CW:0] pow_trunc(input logic [PW-1:0] prod);
    logic sat;
    sat = |prod[PW-1:CW+FB];
    pow_trunc = sat ? {1'b1, UMAX} : {1'b0, prod[CW+FB-1:FB]};
  endfunction

endpackage
`default_nettype wire

// ===== src/ljf_sqrt_pipe.sv =====
// pipelined integer square root, one root bit per stage
`default_nettype none
module ljf_sqrt_pipe import ljf_pkg::*; #(
  parameter int ROOT_W = 33,
  parameter int SIDE_W = 8
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  en_i,
  input  wire logic                  valid_i,
  input  wire logic [2*ROOT_W-1:0]   rad_i,
  input  wire logic [SIDE_W-1:0]     side_i,
  output logic                       valid_o,
  output logic [ROOT_W-1:0]          root_o,
  output logic [SIDE_W-1:0]          side_o
);

  localparam int RAD_W = 2 * ROOT_W;
  localparam int REM_W = ROOT_W + 1;

  logic [ROOT_W-1:0] vld_q;
  logic [REM_W-1:0]  rem_q  [ROOT_W];
  logic [ROOT_W-1:0] root_q [ROOT_W];
  logic [RAD_W-1:0]  rad_q  [ROOT_W];
  logic [SIDE_W-1:0] side_q [ROOT_W];

  for (genvar i = 0; i < ROOT_W; i++) begin : g_stage
    logic              v_in;
    logic [REM_W-1:0]  rem_in;
    logic [ROOT_W-1:0] root_in;
    logic [RAD_W-1:0]  rad_in;
    logic [SIDE_W-1:0] side_in;
    logic [REM_W+1:0]  r2;
    logic [REM_W+1:0]  trial;
    logic              ge;
    logic [REM_W+1:0]  diff;

    // stage input selection
    if (i == 0) begin : g_first
      assign v_in    = valid_i;
      assign rem_in  = '0;
      assign root_in = '0;
      assign rad_in  = rad_i;
      assign side_in = side_i;
    end else begin : g_next
      assign v_in    = vld_q[i-1];
      assign rem_in  = rem_q[i-1];
      assign root_in = root_q[i-1];
      assign rad_in  = rad_q[i-1];
      assign side_in = side_q[i-1];
    end

    // trial subtraction for one root bit
    always_comb begin
      r2    = {rem_in, rad_in[RAD_W-1:RAD_W-2]};
      trial = {1'b0, root_in, 2'b01};
      ge    = r2 >= trial;
      diff  = r2 - trial;
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[i] <= 1'b0;
      end else if (en_i) begin
        vld_q[i] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[i]  <= ge ? diff[REM_W-1:0] : r2[REM_W-1:0];
        root_q[i] <= {root_in[ROOT_W-2:0], ge};
        rad_q[i]  <= {rad_in[RAD_W-3:0], 2'b00};
        side_q[i] <= side_in;
      end
    end
  end

  assign valid_o = vld_q[ROOT_W-1];
  assign root_o  = root_q[ROOT_W-1];
  assign side_o  = side_q[ROOT_W-1];

endmodule
`default_nettype wire

// ===== src/ljf_div_pipe.sv =====
// pipelined restoring divider, one quotient bit per stage
`default_nettype none
module ljf_div_pipe import ljf_pkg::*; #(
  parameter int NUM_W  = 48,
  parameter int DEN_W  = 33,
  parameter int SIDE_W = 8
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              en_i,
  input  wire logic              valid_i,
  input  wire logic [NUM_W-1:0]  num_i,
  input  wire logic [DEN_W-1:0]  den_i,
  input  wire logic [SIDE_W-1:0] side_i,
  output logic                   valid_o,
  output logic [NUM_W-1:0]       quot_o,
  output logic [SIDE_W-1:0]      side_o
);

  localparam int WW = DEN_W + NUM_W;

  logic [NUM_W-1:0]  vld_q;
  logic [WW-1:0]     work_q [NUM_W];
  logic [DEN_W-1:0]  den_q  [NUM_W];
  logic [SIDE_W-1:0] side_q [NUM_W];

  for (genvar i = 0; i < NUM_W; i++) begin : g_stage
    logic              v_in;
    logic [WW-1:0]     w_in;
    logic [DEN_W-1:0]  dn_in;
    logic [SIDE_W-1:0] side_in;
    logic [DEN_W:0]    t;
    logic [DEN_W:0]    diff;
    logic              ge;

    // stage input selection
    if (i == 0) begin : g_first
      assign v_in    = valid_i;
      assign w_in    = {{DEN_W{1'b0}}, num_i};
      assign dn_in   = den_i;
      assign side_in = side_i;
    end else begin : g_next
      assign v_in    = vld_q[i-1];
      assign w_in    = work_q[i-1];
      assign dn_in   = den_q[i-1];
      assign side_in = side_q[i-1];
    end

    // shift in one dividend bit and try the subtraction
    always_comb begin
      t    = {w_in[WW-1:NUM_W], w_in[NUM_W-1]};
      ge   = t >= {1'b0, dn_in};
      diff = t - {1'b0, dn_in};
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[i] <= 1'b0;
      end else if (en_i) begin
        vld_q[i] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        work_q[i] <= {(ge ? diff[DEN_W-1:0] : t[DEN_W-1:0]), w_in[NUM_W-2:0], ge};
        den_q[i]  <= dn_in;
        side_q[i] <= side_in;
      end
    end
  end

  assign valid_o = vld_q[NUM_W-1];
  assign quot_o  = work_q[NUM_W-1][NUM_W-1:0];
  assign side_o  = side_q[NUM_W-1];

endmodule
`default_nettype wire

// ===== src/lennard_jones_pair_force_2d.sv =====
// Lennard-Jones pair force for two points in the plane, fully pipelined.
// Input channel in_valid_i/in_ready_o carries two points (in_t); a transaction
// completes when both are high. Output channel out_valid_o/out_ready_i carries
// the two force components and the coincident and clipped flags (out_t).
// Config channel cfg_valid_i/cfg_ready_o writes the zero-point distance r0;
// cfg_ready_o is always high; the write is registered into r0 and is used by
// pairs that reach the ratio divider after it. Throughput: one pair per cycle
// while the output is not stalled. The pipeline is 33 square root stages, a
// 48-stage ratio divider, 65-stage component dividers and 15 other stages.
// The output register holds a finished result until it is taken; while the
// receiver stalls with a result pending, every stage holds and in_ready_o is
// low, so nothing is lost or repeated.
// Reset clears all valid bits and sets r0 to 1.0 (65536 in Q16.16).
`default_nettype none
module lennard_jones_pair_force_2d import ljf_pkg::*; (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           in_valid_i,
  output logic                in_ready_o,
  input  wire in_t            in_data_i,
  output logic                out_valid_o,
  input  wire logic           out_ready_i,
  output out_t                out_data_o,
  input  wire logic           cfg_valid_i,
  output logic                cfg_ready_o,
  input  wire logic [R0W-1:0] cfg_data_i
);

  logic           en;
  logic [R0W-1:0] r0_q;

  // pipeline advance: output free or being taken
  assign en          = !out_valid_o || out_ready_i;
  assign in_ready_o  = en;
  assign cfg_ready_o = 1'b1;

  // zero-point distance register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      r0_q <= R0_RESET;
    end else if (cfg_valid_i) begin
      r0_q <= cfg_data_i;
    end
  end

  // stage 0: differences, magnitudes and signs
  logic              v0_q;
  geom_t             g0_d, g0_q;
  logic signed [DW-1:0] dx, dy;

  always_comb begin
    dx = DW'(in_data_i.b_x) - DW'(in_data_i.a_x);
    dy = DW'(in_data_i.b_y) - DW'(in_data_i.a_y);
    g0_d.nx    = dx[DW-1];
    g0_d.ny    = dy[DW-1];
    g0_d.mx    = dx[DW-1] ? DW'(-dx) : DW'(dx);
    g0_d.my    = dy[DW-1] ? DW'(-dy) : DW'(dy);
    g0_d.coinc = (dx == '0) && (dy == '0);
  end

  // stage 1: squares; stage 2: sum of squares
  logic           v1_q, v2_q;
  geom_t          g1_q, g2_q;
  logic [SQW-1:0] sx_q, sy_q, sum_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else if (en) begin
      v0_q <= in_valid_i;
      v1_q <= v0_q;
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      g0_q  <= g0_d;
      g1_q  <= g0_q;
      sx_q  <= g0_q.mx * g0_q.mx;
      sy_q  <= g0_q.my * g0_q.my;
      g2_q  <= g1_q;
      sum_q <= sx_q + sy_q;
    end
  end

  // distance
  logic                    sq_v;
  logic [DW-1:0]           sq_root;
  logic [$bits(geom_t)-1:0] sq_side;

  ljf_sqrt_pipe #(
    .ROOT_W (DW),
    .SIDE_W ($bits(geom_t))
  ) u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (v2_q),
    .rad_i   (sum_q),
    .side_i  (g2_q),
    .valid_o (sq_v),
    .root_o  (sq_root),
    .side_o  (sq_side)
  );

  // ratio r0 / d
  dist_t                    dist_in;
  logic                     rd_v;
  logic [NUMW-1:0]          rd_q;
  logic [$bits(dist_t)-1:0] rd_side;

  assign dist_in.g = geom_t'(sq_side);
  assign dist_in.d = sq_root;

  ljf_div_pipe #(
    .NUM_W  (NUMW),
    .DEN_W  (DW),
    .SIDE_W ($bits(dist_t))
  ) u_ratio_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (sq_v),
    .num_i   ({r0_q, {FB{1'b0}}}),
    .den_i   (sq_root),
    .side_i  (dist_in),
    .valid_o (rd_v),
    .quot_o  (rd_q),
    .side_o  (rd_side)
  );

  // power chain: ratio clamp, then alternating product and truncate stages
  localparam int NPOW = 9;
  logic [NPOW-1:0] pv_q;
  pow_t            pw_d [NPOW];
  pow_t            pw_q [NPOW];
  logic [CW:0]     tr   [NPOW];

  always_comb begin
    // ratio saturation
    pw_d[0]      = '0;
    pw_d[0].t    = dist_t'(rd_side);
    pw_d[0].s    = (|rd_q[NUMW-1:CW]) ? UMAX : rd_q[CW-1:0];
    pw_d[0].clip = |rd_q[NUMW-1:CW];
    for (int k = 0; k < NPOW; k++) begin
      tr[k] = pow_trunc(pw_q[k].prod);
    end
    // s*s
    pw_d[1]      = pw_q[0];
    pw_d[1].prod = pw_q[0].s * pw_q[0].s;
    // s2
    pw_d[2]      = pw_q[1];
    pw_d[2].p    = tr[1][CW-1:0];
    pw_d[2].psat = pw_q[1].psat | tr[1][CW];
    // s2*s
    pw_d[3]      = pw_q[2];
    pw_d[3].prod = pw_q[2].p * pw_q[2].s;
    // s3
    pw_d[4]      = pw_q[3];
    pw_d[4].p    = tr[3][CW-1:0];
    pw_d[4].psat = pw_q[3].psat | tr[3][CW];
    // s3*s3
    pw_d[5]      = pw_q[4];
    pw_d[5].prod = pw_q[4].p * pw_q[4].p;
    // s6
    pw_d[6]      = pw_q[5];
    pw_d[6].p    = tr[5][CW-1:0];
    pw_d[6].s6   = tr[5][CW-1:0];
    pw_d[6].psat = pw_q[5].psat | tr[5][CW];
    // s6*s6
    pw_d[7]      = pw_q[6];
    pw_d[7].prod = pw_q[6].p * pw_q[6].p;
    // s12
    pw_d[8]      = pw_q[7];
    pw_d[8].p    = tr[7][CW-1:0];
    pw_d[8].psat = pw_q[7].psat | tr[7][CW];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pv_q <= '0;
    end else if (en) begin
      pv_q <= {pv_q[NPOW-2:0], rd_v};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int k = 0; k < NPOW; k++) begin
        pw_q[k] <= pw_d[k];
      end
    end
  end

  // magnitude s12 - s6, signed and clamped
  logic          mv_q, mneg_d, mneg_q, mclip_d, mclip_q;
  logic [CW-1:0] mm_d, mm_q, mdiff;
  dist_t         mt_q;

  always_comb begin
    mneg_d  = 1'b0;
    mclip_d = pw_q[NPOW-1].clip;
    mdiff   = '0;
    priority if (pw_q[NPOW-1].psat) begin
      mm_d    = MAX_POS;
      mclip_d = 1'b1;
    end else if (pw_q[NPOW-1].p >= pw_q[NPOW-1].s6) begin
      mdiff = pw_q[NPOW-1].p - pw_q[NPOW-1].s6;
      if (mdiff > MAX_POS) begin
        mm_d    = MAX_POS;
        mclip_d = 1'b1;
      end else begin
        mm_d = mdiff;
      end
    end else begin
      mdiff  = pw_q[NPOW-1].s6 - pw_q[NPOW-1].p;
      mneg_d = 1'b1;
      if (mdiff > MIN_MAG) begin
        mm_d    = MIN_MAG;
        mclip_d = 1'b1;
      end else begin
        mm_d = mdiff;
      end
    end
  end

  // component products
  logic           cv_q;
  logic [CPW-1:0] px_q, py_q;
  logic [DW-1:0]  cd_q;
  comp_side_t     csx_q, csy_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mv_q <= 1'b0;
      cv_q <= 1'b0;
    end else if (en) begin
      mv_q <= pv_q[NPOW-1];
      cv_q <= mv_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      mm_q        <= mm_d;
      mneg_q      <= mneg_d;
      mclip_q     <= mclip_d;
      mt_q        <= pw_q[NPOW-1].t;
      px_q        <= mt_q.g.mx * mm_q;
      py_q        <= mt_q.g.my * mm_q;
      cd_q        <= mt_q.d;
      csx_q.neg   <= mt_q.g.nx ^ mneg_q;
      csx_q.coinc <= mt_q.g.coinc;
      csx_q.clip  <= mclip_q;
      csy_q.neg   <= mt_q.g.ny ^ mneg_q;
      csy_q.coinc <= mt_q.g.coinc;
      csy_q.clip  <= mclip_q;
    end
  end

  // component division by d
  logic                          qxv, qyv;
  logic [CPW-1:0]                qx, qy;
  logic [$bits(comp_side_t)-1:0] sxo, syo;

  ljf_div_pipe #(
    .NUM_W  (CPW),
    .DEN_W  (DW),
    .SIDE_W ($bits(comp_side_t))
  ) u_x_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (cv_q),
    .num_i   (px_q),
    .den_i   (cd_q),
    .side_i  (csx_q),
    .valid_o (qxv),
    .quot_o  (qx),
    .side_o  (sxo)
  );

  ljf_div_pipe #(
    .NUM_W  (CPW),
    .DEN_W  (DW),
    .SIDE_W ($bits(comp_side_t))
  ) u_y_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (cv_q),
    .num_i   (py_q),
    .den_i   (cd_q),
    .side_i  (csy_q),
    .valid_o (qyv),
    .quot_o  (qy),
    .side_o  (syo)
  );

  // final clamp, sign and coincident override
  comp_side_t    fx, fy;
  logic          ovx, ovy;
  logic [CW-1:0] vx, vy;
  out_t          out_d, out_q;
  logic          out_vld_q;

  always_comb begin
    fx  = comp_side_t'(sxo);
    fy  = comp_side_t'(syo);
    ovx = (|qx[CPW-1:CW]) ||
          (fx.neg ? (qx[CW-1] && (|qx[CW-2:0])) : qx[CW-1]);
    ovy = (|qy[CPW-1:CW]) ||
          (fy.neg ? (qy[CW-1] && (|qy[CW-2:0])) : qy[CW-1]);
    vx  = ovx ? (fx.neg ? MIN_MAG : MAX_POS) : qx[CW-1:0];
    vy  = ovy ? (fy.neg ? MIN_MAG : MAX_POS) : qy[CW-1:0];
    if (fx.coinc) begin
      out_d.force_x    = '0;
      out_d.force_y    = '0;
      out_d.coincident = 1'b1;
      out_d.clipped    = 1'b0;
    end else begin
      out_d.force_x    = fx.neg ? -vx : vx;
      out_d.force_y    = fy.neg ? -vy : vy;
      out_d.coincident = 1'b0;
      out_d.clipped    = fx.clip | ovx | ovy;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (en) begin
      out_vld_q <= qxv & qyv;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

endmodule
`default_nettype wire
